FILE: rtl/core/open_address_hash_table_defines.svh
// assertion macros for the hash table checker
`ifndef OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH

// implication in the same cycle
`define OAHT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed");

// implication in the next cycle
`define OAHT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");

`endif

FILE: rtl/core/oaht_pkg.sv
// shared types, codes and key functions of the hash table
`default_nettype none
package oaht_pkg;
    typedef logic [1:0] t_req;
    typedef logic [2:0] t_status;

    localparam t_req REQ_FIND   = 2'd0;
    localparam t_req REQ_STORE  = 2'd1;
    localparam t_req REQ_DELETE = 2'd2;
    localparam t_req REQ_CLEAR  = 2'd3;

    localparam t_status ST_HIT     = 3'd0;
    localparam t_status ST_MISS    = 3'd1;
    localparam t_status ST_STORED  = 3'd2;
    localparam t_status ST_REMOVED = 3'd3;
    localparam t_status ST_FULL    = 3'd4;
    localparam t_status ST_CLEARED = 3'd5;

    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_HASH_ONLY  = 1'b1;

    localparam int KEY_W      = 64;
    localparam int HASH_W     = 21;
    localparam int CNT_W      = 10;
    localparam int SLOT_W     = 9;
    localparam int MOD_BITS   = 3;
    localparam int MOD_CYC    = HASH_W / MOD_BITS;
    localparam int HASH_MUL   = 157;
    localparam int SHIFT_MUL  = 11;
    localparam int SHIFT_MASK = 15;

    localparam logic [9:0] SIZE_RESET = 10'd509;
    localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

    // bytes before the first zero byte, within the key length
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] key,
                                                  input int unsigned nbytes);
        logic [KEY_W-1:0] n;
        logic alive;
        n = '0;
        alive = 1'b1;
        for (int k = 0; k < 8; k++) begin
            if (key[8*k +: 8] == 8'h00 || k >= nbytes) alive = 1'b0;
            if (alive) n[8*k +: 8] = key[8*k +: 8];
        end
        return n;
    endfunction

    // xor of shuffled bytes, zero bytes add nothing
    function automatic logic [HASH_W-1:0] key_hash(input logic [KEY_W-1:0] key);
        logic [HASH_W-1:0] h;
        logic [15:0] p;
        h = '0;
        for (int k = 0; k < 8; k++) begin
            int sh;
            sh = (SHIFT_MUL * (k + 1)) & SHIFT_MASK;
            p = 16'(key[8*k +: 8]) * 16'(HASH_MUL);
            h = h ^ (HASH_W'(p[7:0]) << sh);
        end
        return h;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/oaht_ram.sv
// generic single write, single read ram with registered read
`default_nettype none
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: rtl/core/oaht_front.sv
// front end: accepts requests, hashes the key and finds the start slot
`default_nettype none
module oaht_front #(
    parameter int MAX_SLOTS  = 512,
    parameter int KEY_BYTES  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_hold,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire oaht_pkg::t_req                   i_req,
    input  wire logic [oaht_pkg::KEY_W-1:0]       i_key,
    input  wire logic [DATA_WIDTH-1:0]            i_data,
    input  wire logic [$clog2(MAX_SLOTS):0]       i_size,
    output logic                                  o_q_valid,
    input  wire logic                             i_q_ready,
    output oaht_pkg::t_req                        o_req,
    output logic [oaht_pkg::KEY_W-1:0]            o_key,
    output logic [oaht_pkg::HASH_W-1:0]           o_hash,
    output logic [$clog2(MAX_SLOTS)-1:0]          o_start,
    output logic [DATA_WIDTH-1:0]                 o_data
);
    localparam int IW   = $clog2(MAX_SLOTS);
    localparam int CNTW = $clog2(oaht_pkg::MOD_CYC + 1);
    localparam int HW   = oaht_pkg::HASH_W;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MOD  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                    r_state;
    oaht_pkg::t_req                r_req;
    logic [oaht_pkg::KEY_W-1:0]    r_key;
    logic [HW-1:0]                 r_hash;
    logic [HW-1:0]                 r_shreg;
    logic [IW-1:0]                 r_rem;
    logic [CNTW-1:0]               r_cnt;
    logic [DATA_WIDTH-1:0]         r_data;
    logic [HW-1:0]                 n_shreg;
    logic [IW-1:0]                 n_rem;
    logic [oaht_pkg::KEY_W-1:0]    norm;
    logic                          accept;

    assign o_stall = (r_state != F_IDLE) || i_hold;
    assign accept  = i_valid && !o_stall;
    assign norm    = oaht_pkg::norm_key(i_key, KEY_BYTES);

    // restoring remainder, MOD_BITS hash bits per cycle
    always_comb begin
        logic [IW:0] tmp;
        n_rem   = r_rem;
        n_shreg = r_shreg;
        for (int j = 0; j < oaht_pkg::MOD_BITS; j++) begin
            tmp     = {n_rem, n_shreg[HW-1]};
            n_shreg = n_shreg << 1;
            if (tmp >= i_size) tmp = tmp - i_size;
            n_rem = tmp[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) r_state <= F_MOD;
                end
                F_MOD: begin
                    if (r_cnt == CNTW'(oaht_pkg::MOD_CYC - 1)) r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_q_ready) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req;
            r_key   <= norm;
            r_hash  <= oaht_pkg::key_hash(norm);
            r_shreg <= oaht_pkg::key_hash(norm);
            r_data  <= i_data;
            r_rem   <= '0;
            r_cnt   <= '0;
        end else if (r_state == F_MOD) begin
            r_shreg <= n_shreg;
            r_rem   <= n_rem;
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    assign o_q_valid = (r_state == F_PUSH);
    assign o_req     = r_req;
    assign o_key     = r_key;
    assign o_hash    = r_hash;
    assign o_start   = r_rem;
    assign o_data    = r_data;
endmodule
`default_nettype wire

FILE: rtl/core/oaht_queue.sv
// two-word queue between front and back end
`default_nettype none
module oaht_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            if (push && !pop) r_cnt <= r_cnt + 2'd1;
            else if (pop && !push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_wdata;
    end
endmodule
`default_nettype wire

FILE: rtl/core/oaht_back.sv
// back end: clears and probes the slot ram, updates entries and issues results
`default_nettype none
module oaht_back #(
    parameter int MAX_SLOTS  = 512,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    output logic                                  o_init,
    input  wire logic                             i_q_valid,
    output logic                                  o_q_pop,
    input  wire oaht_pkg::t_req                   i_req,
    input  wire logic [oaht_pkg::KEY_W-1:0]       i_key,
    input  wire logic [oaht_pkg::HASH_W-1:0]      i_hash,
    input  wire logic [$clog2(MAX_SLOTS)-1:0]     i_start,
    input  wire logic [DATA_WIDTH-1:0]            i_data,
    input  wire logic [$clog2(MAX_SLOTS):0]       i_size,
    input  wire logic                             i_hash_only,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output oaht_pkg::t_status                     o_status,
    output logic [oaht_pkg::SLOT_W-1:0]           o_slot,
    output logic [DATA_WIDTH-1:0]                 o_data_out,
    output logic [oaht_pkg::HASH_W-1:0]           o_key_hash,
    output logic [oaht_pkg::CNT_W-1:0]            o_removed_total
);
    localparam int IW = $clog2(MAX_SLOTS);
    localparam int SW = IW + 1;
    localparam int HW = oaht_pkg::HASH_W;
    localparam int KW = oaht_pkg::KEY_W;
    localparam int DW = DATA_WIDTH;
    localparam int WW = 2 + HW + KW + DW;

    localparam logic [1:0] B_SWEEP = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_CHECK = 2'd2;
    localparam logic [1:0] B_RES   = 2'd3;

    logic [1:0]                    r_state;
    logic                          r_init;
    logic [IW-1:0]                 r_clr;
    oaht_pkg::t_req                r_req;
    logic [KW-1:0]                 r_key;
    logic [HW-1:0]                 r_hash;
    logic [DW-1:0]                 r_data;
    logic [IW-1:0]                 r_ndx;
    logic [IW-1:0]                 r_step;
    logic [SW-1:0]                 r_tries;
    logic [oaht_pkg::CNT_W-1:0]    r_cnt;
    oaht_pkg::t_status             r_rs_status;
    logic [IW-1:0]                 r_rs_slot;
    logic [DW-1:0]                 r_rs_dout;
    logic                          r_out_valid;
    oaht_pkg::t_status             r_out_status;
    logic [oaht_pkg::SLOT_W-1:0]   r_out_slot;
    logic [DW-1:0]                 r_out_dout;
    logic [HW-1:0]                 r_out_hash;
    logic [oaht_pkg::CNT_W-1:0]    r_out_removed;

    logic [WW-1:0]                 rdata;
    logic                          rd_used;
    logic                          rd_live;
    logic [HW-1:0]                 rd_hash;
    logic [KW-1:0]                 rd_key;
    logic [DW-1:0]                 rd_data;
    logic                          match;
    logic                          last;
    logic [IW:0]                   nx;
    logic [IW:0]                   st;
    logic                          we;
    logic [IW-1:0]                 waddr;
    logic [WW-1:0]                 wdata;
    logic [IW-1:0]                 raddr;
    logic                          out_free;
    logic [IW+oaht_pkg::SLOT_W-1:0] slot_ext;

    assign rd_used = rdata[WW-1];
    assign rd_live = rdata[WW-2];
    assign rd_hash = rdata[WW-3 -: HW];
    assign rd_key  = rdata[DW +: KW];
    assign rd_data = rdata[DW-1:0];
    assign match   = rd_used && (rd_hash == r_hash) && (i_hash_only || rd_key == r_key);
    assign last    = (r_tries + 1'b1) == i_size;
    assign o_q_pop = (r_state == B_IDLE);
    assign o_init  = r_init;
    assign out_free = !r_out_valid || !i_out_stall;
    assign slot_ext = {{oaht_pkg::SLOT_W{1'b0}}, r_rs_slot};

    always_comb begin
        nx = {1'b0, r_ndx} + {1'b0, r_step};
        if (nx >= i_size) nx = nx - i_size;
        st = {1'b0, r_step} + (IW+1)'(2);
        if (st >= i_size) st = st - i_size;
    end

    assign raddr = (r_state == B_IDLE) ? i_start : nx[IW-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = r_ndx;
        wdata = '0;
        unique case (r_state)
            B_SWEEP: begin
                we    = 1'b1;
                waddr = r_clr;
            end
            B_CHECK: begin
                if (!rd_used && r_req == oaht_pkg::REQ_STORE) begin
                    we    = 1'b1;
                    wdata = {1'b1, 1'b1, r_hash, r_key, r_data};
                end else if (match && r_req == oaht_pkg::REQ_STORE) begin
                    we    = 1'b1;
                    wdata = {1'b1, 1'b1, rd_hash, rd_key, r_data};
                end else if (match && rd_live && r_req == oaht_pkg::REQ_DELETE) begin
                    we    = 1'b1;
                    wdata = {1'b1, 1'b0, rd_hash, rd_key, {DW{1'b0}}};
                end
            end
            default: we = 1'b0;
        endcase
    end

    oaht_ram #(.WIDTH(WW), .DEPTH(MAX_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_SWEEP;
            r_init      <= 1'b1;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != B_RES) r_out_valid <= 1'b0;
            unique case (r_state)
                B_SWEEP: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IW'(MAX_SLOTS - 1)) begin
                        r_init      <= 1'b0;
                        r_state     <= r_init ? B_IDLE : B_RES;
                        r_rs_status <= oaht_pkg::ST_CLEARED;
                        r_rs_slot   <= '0;
                        r_rs_dout   <= '0;
                    end
                end
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_req   <= i_req;
                        r_key   <= i_key;
                        r_hash  <= i_hash;
                        r_data  <= i_data;
                        r_ndx   <= i_start;
                        r_step  <= IW'(1);
                        r_tries <= '0;
                        if (i_req == oaht_pkg::REQ_CLEAR) begin
                            r_clr   <= '0;
                            r_cnt   <= '0;
                            r_state <= B_SWEEP;
                        end else begin
                            r_state <= B_CHECK;
                        end
                    end
                end
                B_CHECK: begin
                    if (!rd_used) begin
                        r_state     <= B_RES;
                        r_rs_slot   <= r_ndx;
                        r_rs_dout   <= '0;
                        r_rs_status <= (r_req == oaht_pkg::REQ_STORE) ?
                                       oaht_pkg::ST_STORED : oaht_pkg::ST_MISS;
                    end else if (match) begin
                        r_state   <= B_RES;
                        r_rs_slot <= r_ndx;
                        r_rs_dout <= (r_req == oaht_pkg::REQ_FIND && rd_live) ?
                                     rd_data : '0;
                        unique case (r_req)
                            oaht_pkg::REQ_FIND: begin
                                r_rs_status <= rd_live ? oaht_pkg::ST_HIT : oaht_pkg::ST_MISS;
                            end
                            oaht_pkg::REQ_STORE: begin
                                r_rs_status <= oaht_pkg::ST_STORED;
                                if (!rd_live && r_cnt != '0) r_cnt <= r_cnt - 1'b1;
                            end
                            oaht_pkg::REQ_DELETE: begin
                                r_rs_status <= rd_live ? oaht_pkg::ST_REMOVED :
                                               oaht_pkg::ST_MISS;
                                if (rd_live && r_cnt != oaht_pkg::CNT_MAX)
                                    r_cnt <= r_cnt + 1'b1;
                            end
                            default: r_rs_status <= oaht_pkg::ST_MISS;
                        endcase
                    end else if (last) begin
                        r_state     <= B_RES;
                        r_rs_status <= oaht_pkg::ST_FULL;
                        r_rs_slot   <= '0;
                        r_rs_dout   <= '0;
                    end else begin
                        r_ndx   <= nx[IW-1:0];
                        r_step  <= st[IW-1:0];
                        r_tries <= r_tries + 1'b1;
                    end
                end
                B_RES: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= r_rs_status;
                        r_out_slot    <= slot_ext[oaht_pkg::SLOT_W-1:0];
                        r_out_dout    <= r_rs_dout;
                        r_out_hash    <= r_hash;
                        r_out_removed <= r_cnt;
                        r_state       <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot          = r_out_slot;
    assign o_data_out      = r_out_dout;
    assign o_key_hash      = r_out_hash;
    assign o_removed_total = r_out_removed;
endmodule
`default_nettype wire

FILE: rtl/core/open_address_hash_table.sv
// top level of the open addressing hash table
`default_nettype none
// Keyed table with quadratic probing over one slot ram of MAX_SLOTS words.
// The front end hashes the key as it takes a request and reduces the hash
// modulo the table size three bits a cycle; it takes no new request until
// the last is in the queue. A two-word queue hands requests to the back end,
// which reads the ram once per probed slot. A clear request, and the pass
// after reset during which no request is taken, sweeps the ram. Results
// leave through an output register, so the back end runs while one waits.
module open_address_hash_table #(
    parameter int MAX_SLOTS  = 512,
    parameter int KEY_BYTES  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           i_cfg_index,
    input  wire logic [9:0]                     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire oaht_pkg::t_req                 i_req_type,
    input  wire logic [oaht_pkg::KEY_W-1:0]     i_key,
    input  wire logic [DATA_WIDTH-1:0]          i_data_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output oaht_pkg::t_status                   o_status,
    output logic [oaht_pkg::SLOT_W-1:0]         o_slot,
    output logic [DATA_WIDTH-1:0]               o_data_out,
    output logic [oaht_pkg::HASH_W-1:0]         o_key_hash,
    output logic [oaht_pkg::CNT_W-1:0]          o_removed_total
);
    localparam int IW = $clog2(MAX_SLOTS);
    localparam int SW = IW + 1;
    localparam int CW = (SW > 10) ? SW : 10;
    localparam int HW = oaht_pkg::HASH_W;
    localparam int KW = oaht_pkg::KEY_W;
    localparam int QW = 2 + KW + HW + IW + DATA_WIDTH;

    logic [9:0]              r_table_size;
    logic                    r_hash_only;
    logic [CW-1:0]           ts_ext;
    logic [SW-1:0]           size;
    logic                    init;
    logic                    f_valid;
    logic                    q_ready;
    oaht_pkg::t_req          f_req;
    logic [KW-1:0]           f_key;
    logic [HW-1:0]           f_hash;
    logic [IW-1:0]           f_start;
    logic [DATA_WIDTH-1:0]   f_data;
    logic [QW-1:0]           q_rdata;
    logic                    q_valid;
    logic                    q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= oaht_pkg::SIZE_RESET;
            r_hash_only  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                oaht_pkg::CFG_TABLE_SIZE: r_table_size <= i_cfg_data;
                oaht_pkg::CFG_HASH_ONLY:  r_hash_only  <= i_cfg_data[0];
                default:                  r_hash_only  <= r_hash_only;
            endcase
        end
    end

    always_comb begin
        ts_ext = CW'(r_table_size);
        if (ts_ext < CW'(2)) ts_ext = CW'(2);
        else if (ts_ext > CW'(MAX_SLOTS)) ts_ext = CW'(MAX_SLOTS);
        size = ts_ext[SW-1:0];
    end

    oaht_front #(
        .MAX_SLOTS(MAX_SLOTS), .KEY_BYTES(KEY_BYTES), .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hold    (init),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_req     (i_req_type),
        .i_key     (i_key),
        .i_data    (i_data_in),
        .i_size    (size),
        .o_q_valid (f_valid),
        .i_q_ready (q_ready),
        .o_req     (f_req),
        .o_key     (f_key),
        .o_hash    (f_hash),
        .o_start   (f_start),
        .o_data    (f_data)
    );

    oaht_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .i_wdata ({f_req, f_key, f_hash, f_start, f_data}),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rdata (q_rdata)
    );

    oaht_back #(.MAX_SLOTS(MAX_SLOTS), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .o_init          (init),
        .i_q_valid       (q_valid),
        .o_q_pop         (q_pop),
        .i_req           (q_rdata[QW-1 -: 2]),
        .i_key           (q_rdata[QW-3 -: KW]),
        .i_hash          (q_rdata[QW-3-KW -: HW]),
        .i_start         (q_rdata[DATA_WIDTH +: IW]),
        .i_data          (q_rdata[DATA_WIDTH-1:0]),
        .i_size          (size),
        .i_hash_only     (r_hash_only),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_data_out      (o_data_out),
        .o_key_hash      (o_key_hash),
        .o_removed_total (o_removed_total)
    );
endmodule
`default_nettype wire

FILE: rtl/core/oaht_checker.sv
// port checker for the hash table and its bind
`default_nettype none
`include "open_address_hash_table_defines.svh"
module oaht_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire oaht_pkg::t_status            o_status,
    input wire logic [oaht_pkg::SLOT_W-1:0]  o_slot,
    input wire logic [DATA_WIDTH-1:0]        o_data_out,
    input wire logic [oaht_pkg::CNT_W-1:0]   o_removed_total
);
    logic res_zero;
    logic cleared;

    assign res_zero = o_removed_total == '0 && o_slot == '0 && o_data_out == '0;
    assign cleared  = o_out_valid && o_status == oaht_pkg::ST_CLEARED;

    `OAHT_ASSERT_NXT(a_out_held, o_out_valid && i_out_stall, o_out_valid)
    `OAHT_ASSERT_IMP(a_status_code, o_out_valid, o_status <= oaht_pkg::ST_CLEARED)
    `OAHT_ASSERT_IMP(a_clear_zero, cleared, res_zero)
    `OAHT_ASSERT_IMP(a_data_hit_only, o_out_valid && o_status != oaht_pkg::ST_HIT, o_data_out == '0)
endmodule

bind open_address_hash_table oaht_checker #(.DATA_WIDTH(DATA_WIDTH)) u_oaht_checker (.*);
`default_nettype wire
